// ----- hdl/next_fit_id_allocator_unit_assert.svh -----
// Assertion macros for the next-fit ID allocator.
// Included by the top level; depends on nothing else.
`ifndef NEXT_FIT_ID_ALLOCATOR_UNIT_ASSERT_SVH
`define NEXT_FIT_ID_ALLOCATOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NFIA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NFIA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/nfia_pkg.sv -----
// Shared constants, codes, result type and sizing functions of the ID allocator.
// Depends on nothing.
`timescale 1ns / 1ps

package nfia_pkg;

   localparam int ID_COUNT_DEF = 1024;
   localparam int WORD_BITS    = 32;
   localparam int WORD_SHIFT   = 5;
   localparam int ID_FIELD_W   = 10;
   localparam int STATUS_W     = 2;

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL        = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_RELEASE = 2'd2;

   typedef struct packed {
      logic [ID_FIELD_W-1:0] granted_id;
      logic [STATUS_W-1:0]   status;
   } nfia_result_type;

   function automatic int nfia_words(input int id_count);
      return (id_count + WORD_BITS - 1) >> WORD_SHIFT;
   endfunction

   function automatic int nfia_addr_w(input int id_count);
      return (nfia_words(id_count) > 1) ? $clog2(nfia_words(id_count)) : 1;
   endfunction

endpackage

// ----- hdl/nfia_if.sv -----
// Request and response channel interfaces of the ID allocator.
// Depends on nfia_pkg for the field widths.
`timescale 1ns / 1ps

interface nfia_req_if;
   import nfia_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  op;
   logic [ID_FIELD_W-1:0] release_id;

   modport source (output valid, op, release_id, input ready);
   modport sink (input valid, op, release_id, output ready);
endinterface

interface nfia_rsp_if;
   import nfia_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [ID_FIELD_W-1:0] granted_id;
   logic [STATUS_W-1:0]   status;

   modport source (output valid, granted_id, status, input ready);
   modport sink (input valid, granted_id, status, output ready);
endinterface

// ----- hdl/next_fit_id_allocator_unit.sv -----
// Top level of the next-fit ID allocator: sequencer, bitmap memory and response register.
// Depends on nfia_pkg, nfia_if, nfia_ctrl, nfia_bitmap_ram and the assertion header.
// The block hands out unique nonzero IDs below ID_COUNT and takes them back. IDs in
// use sit in a bitmap memory of 32-bit words, one read per cycle. After reset a
// clearing pass writes every word, during which no request is taken. An allocate
// reads words in turn starting at the word of the ID issued last, one word per
// cycle, and stops at the first free ID or, once the search has wrapped all the
// way round, answers full; the word scan sets the rate. A release reads one word
// and rewrites it when the ID was in use.
// One request is worked on at a time; the next is taken once the result has moved
// into the response register, even while that register still waits to be taken.
`timescale 1ns / 1ps

module next_fit_id_allocator_unit #(
   parameter int ID_COUNT = nfia_pkg::ID_COUNT_DEF
) (
   input logic        clock,
   input logic        reset,
   nfia_req_if.sink   req_chan,
   nfia_rsp_if.source rsp_chan
);
   import nfia_pkg::*;

   localparam int AW = nfia_addr_w(ID_COUNT);

   logic                 res_valid;
   logic                 res_ready;
   nfia_result_type      res;
   logic                 mem_rd_en;
   logic [AW-1:0]        mem_rd_addr;
   logic [WORD_BITS-1:0] mem_rd_data;
   logic                 mem_wr_en;
   logic [AW-1:0]        mem_wr_addr;
   logic [WORD_BITS-1:0] mem_wr_data;

   logic                 rsp_valid_ff, rsp_valid_in;
   nfia_result_type      rsp_data_ff;
   logic                 res_load;

   nfia_ctrl #(
      .ID_COUNT (ID_COUNT)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_ready      (req_chan.ready),
      .req_op         (req_chan.op),
      .req_release_id (req_chan.release_id),
      .res_valid      (res_valid),
      .res_ready      (res_ready),
      .res            (res),
      .mem_rd_en      (mem_rd_en),
      .mem_rd_addr    (mem_rd_addr),
      .mem_rd_data    (mem_rd_data),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data)
   );

   nfia_bitmap_ram #(
      .ID_COUNT (ID_COUNT)
   ) u_bitmap_ram (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   assign res_ready    = !rsp_valid_ff || rsp_chan.ready;
   assign res_load     = res_valid && res_ready;
   assign rsp_valid_in = res_load || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.granted_id = rsp_data_ff.granted_id;
   assign rsp_chan.status     = rsp_data_ff.status;

`include "next_fit_id_allocator_unit_assert.svh"

   `NFIA_ASSERT_NEXT(a_busy_after_req, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready, "request taken while a request is in progress")
   `NFIA_ASSERT_NEXT(a_result_moves, clock, reset, res_valid && res_ready, rsp_chan.valid, "finished result not presented")
   `NFIA_ASSERT_SAME(a_fail_zero_id, clock, reset, rsp_chan.valid && (rsp_chan.status != ST_OK), rsp_chan.granted_id == '0, "failed request carries an ID")
   `NFIA_ASSERT_SAME(a_status_code, clock, reset, rsp_chan.valid, (rsp_chan.status == ST_OK) || (rsp_chan.status == ST_FULL) || (rsp_chan.status == ST_BAD_RELEASE), "undefined status code")

endmodule

// ----- hdl/nfia_bitmap_ram.sv -----
// Word-organized bitmap memory of IDs in use, one write and one registered read port.
// Depends on nfia_pkg for the word width and sizing functions.
`timescale 1ns / 1ps

module nfia_bitmap_ram #(
   parameter int ID_COUNT = nfia_pkg::ID_COUNT_DEF
) (
   input  logic                                         clock,
   input  logic                                         rd_en,
   input  logic [nfia_pkg::nfia_addr_w(ID_COUNT)-1:0]   rd_addr,
   output logic [nfia_pkg::WORD_BITS-1:0]               rd_data,
   input  logic                                         wr_en,
   input  logic [nfia_pkg::nfia_addr_w(ID_COUNT)-1:0]   wr_addr,
   input  logic [nfia_pkg::WORD_BITS-1:0]               wr_data
);
   import nfia_pkg::*;

   localparam int WORDS = nfia_words(ID_COUNT);

   logic [WORD_BITS-1:0] mem [WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/nfia_ctrl.sv -----
// Sequencer of the ID allocator: clearing pass, next-fit word scan and release check.
// Depends on nfia_pkg; drives the ports of nfia_bitmap_ram.
`timescale 1ns / 1ps

module nfia_ctrl #(
   parameter int ID_COUNT = nfia_pkg::ID_COUNT_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_valid,
   output logic                                         req_ready,
   input  logic                                         req_op,
   input  logic [nfia_pkg::ID_FIELD_W-1:0]              req_release_id,
   output logic                                         res_valid,
   input  logic                                         res_ready,
   output nfia_pkg::nfia_result_type                    res,
   output logic                                         mem_rd_en,
   output logic [nfia_pkg::nfia_addr_w(ID_COUNT)-1:0]   mem_rd_addr,
   input  logic [nfia_pkg::WORD_BITS-1:0]               mem_rd_data,
   output logic                                         mem_wr_en,
   output logic [nfia_pkg::nfia_addr_w(ID_COUNT)-1:0]   mem_wr_addr,
   output logic [nfia_pkg::WORD_BITS-1:0]               mem_wr_data
);
   import nfia_pkg::*;

   localparam int WORDS     = nfia_words(ID_COUNT);
   localparam int AW        = nfia_addr_w(ID_COUNT);
   localparam int BW        = WORD_SHIFT;
   localparam int XW        = AW + BW;
   localparam int IW        = $clog2(ID_COUNT);
   localparam int CW        = $clog2(WORDS + 1);
   localparam int LAST_BITS = ID_COUNT - (WORDS - 1) * WORD_BITS;
   localparam logic [WORD_BITS-1:0] LAST_MASK =
      {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);

   localparam logic [2:0] S_CLEAR   = 3'd0;
   localparam logic [2:0] S_IDLE    = 3'd1;
   localparam logic [2:0] S_SCAN    = 3'd2;
   localparam logic [2:0] S_REL_CHK = 3'd3;
   localparam logic [2:0] S_RESULT  = 3'd4;

   function automatic logic [BW-1:0] low_index(input logic [WORD_BITS-1:0] v);
      logic [BW-1:0] idx;
      idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = BW'(i);
         end
      end
      return idx;
   endfunction

   logic [2:0]      state_ff, state_in;
   logic [AW-1:0]   clr_addr_ff, clr_addr_in;
   logic [IW-1:0]   last_ff, last_in;
   logic [AW-1:0]   addr_ff, addr_in;
   logic [CW-1:0]   k_ff, k_in;
   logic            issue_ff, issue_in;
   logic            dvalid_ff, dvalid_in;
   logic [AW-1:0]   daddr_ff, daddr_in;
   logic [CW-1:0]   dk_ff, dk_in;
   logic [BW-1:0]   sb_ff, sb_in;
   logic [AW-1:0]   rel_addr_ff, rel_addr_in;
   logic [BW-1:0]   rel_bit_ff, rel_bit_in;
   nfia_result_type res_ff, res_in;

   logic                 accept;
   logic [XW-1:0]        start_ext;
   logic                 id_ok;
   logic [WORD_BITS-1:0] mask;
   logic [WORD_BITS-1:0] free_bits;
   logic [BW-1:0]        free_pos;
   logic [WORD_BITS-1:0] pos_onehot;
   logic [WORD_BITS-1:0] rel_onehot;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign res_valid = (state_ff == S_RESULT);
   assign res       = res_ff;
   assign start_ext = XW'(last_ff);
   assign id_ok     = (req_release_id != '0) && (32'(req_release_id) < ID_COUNT);

   always_comb begin
      mask = (daddr_ff == AW'(WORDS - 1)) ? LAST_MASK : {WORD_BITS{1'b1}};
      if (daddr_ff == '0) begin
         mask[0] = 1'b0;
      end
      if (dk_ff == '0) begin
         mask = mask & (({WORD_BITS{1'b1}} << sb_ff) << 1);
      end
      if (dk_ff == CW'(WORDS)) begin
         mask = mask & ~({WORD_BITS{1'b1}} << sb_ff);
      end
   end

   assign free_bits  = ~mem_rd_data & mask;
   assign free_pos   = low_index(free_bits);
   assign pos_onehot = WORD_BITS'(1) << free_pos;
   assign rel_onehot = WORD_BITS'(1) << rel_bit_ff;

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      last_in     = last_ff;
      addr_in     = addr_ff;
      k_in        = k_ff;
      issue_in    = issue_ff;
      dvalid_in   = 1'b0;
      daddr_in    = addr_ff;
      dk_in       = k_ff;
      sb_in       = sb_ff;
      rel_addr_in = rel_addr_ff;
      rel_bit_in  = rel_bit_ff;
      res_in      = res_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = addr_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = clr_addr_ff;
      mem_wr_data = '0;
      case (state_ff)
         S_CLEAR: begin
            mem_wr_en   = 1'b1;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (req_op == OP_ALLOC) begin
                  addr_in  = start_ext[XW-1:BW];
                  sb_in    = start_ext[BW-1:0];
                  k_in     = '0;
                  issue_in = 1'b1;
                  state_in = S_SCAN;
               end else if (id_ok) begin
                  rel_addr_in = AW'(req_release_id >> BW);
                  rel_bit_in  = req_release_id[BW-1:0];
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = AW'(req_release_id >> BW);
                  state_in    = S_REL_CHK;
               end else begin
                  res_in.granted_id = '0;
                  res_in.status     = ST_BAD_RELEASE;
                  state_in          = S_RESULT;
               end
            end
         end
         S_SCAN: begin
            if (issue_ff) begin
               mem_rd_en = 1'b1;
               dvalid_in = 1'b1;
               addr_in   = (addr_ff == AW'(WORDS - 1)) ? '0 : addr_ff + AW'(1);
               k_in      = k_ff + CW'(1);
               if (k_ff == CW'(WORDS)) begin
                  issue_in = 1'b0;
               end
            end
            if (dvalid_ff) begin
               if (free_bits != '0) begin
                  mem_wr_en         = 1'b1;
                  mem_wr_addr       = daddr_ff;
                  mem_wr_data       = mem_rd_data | pos_onehot;
                  last_in           = IW'({daddr_ff, free_pos});
                  res_in.granted_id = ID_FIELD_W'({daddr_ff, free_pos});
                  res_in.status     = ST_OK;
                  issue_in          = 1'b0;
                  dvalid_in         = 1'b0;
                  state_in          = S_RESULT;
               end else if (dk_ff == CW'(WORDS)) begin
                  res_in.granted_id = '0;
                  res_in.status     = ST_FULL;
                  issue_in          = 1'b0;
                  dvalid_in         = 1'b0;
                  state_in          = S_RESULT;
               end
            end
         end
         S_REL_CHK: begin
            res_in.granted_id = '0;
            if (mem_rd_data[rel_bit_ff]) begin
               mem_wr_en     = 1'b1;
               mem_wr_addr   = rel_addr_ff;
               mem_wr_data   = mem_rd_data & ~rel_onehot;
               res_in.status = ST_OK;
            end else begin
               res_in.status = ST_BAD_RELEASE;
            end
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_addr_ff <= '0;
         last_ff     <= '0;
         issue_ff    <= 1'b0;
         dvalid_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         last_ff     <= last_in;
         issue_ff    <= issue_in;
         dvalid_ff   <= dvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      k_ff        <= k_in;
      daddr_ff    <= daddr_in;
      dk_ff       <= dk_in;
      sb_ff       <= sb_in;
      rel_addr_ff <= rel_addr_in;
      rel_bit_ff  <= rel_bit_in;
      res_ff      <= res_in;
   end

endmodule

// ----- dv/next_fit_id_allocator_unit_checker.sv -----
// Response checker for the next-fit ID allocator: it keeps its own copy of the ID
// bitmap, predicts the response of every request transfer and compares it in order.
// Depends on nfia_pkg for widths, operation codes, status codes and the result type.
`timescale 1ns / 1ps

module next_fit_id_allocator_unit_checker #(
   parameter int ID_COUNT = nfia_pkg::ID_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic                            req_op,
   input  logic [nfia_pkg::ID_FIELD_W-1:0] req_release_id,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [nfia_pkg::ID_FIELD_W-1:0] rsp_granted_id,
   input  logic [nfia_pkg::STATUS_W-1:0]   rsp_status,
   output int                              failures,
   output int                              pending,
   output int                              grants,
   output int                              full_answers,
   output int                              releases_ok,
   output int                              releases_bad
);
   import nfia_pkg::*;

   bit              id_in_use [ID_COUNT];
   int unsigned     last_granted;
   nfia_result_type awaited_rsps [$];

   function automatic nfia_result_type next_fit_outcome(input logic op,
                                                        input logic [ID_FIELD_W-1:0] id);
      nfia_result_type res;
      int unsigned     cand;
      bit              found;
      res.granted_id = '0;
      res.status     = ST_OK;
      found          = 1'b0;
      if (op == OP_ALLOC) begin
         for (int step = 1; step < ID_COUNT && !found; step++) begin
            cand = (last_granted + step) % ID_COUNT;
            if (cand != 0 && !id_in_use[cand]) begin
               id_in_use[cand] = 1'b1;
               last_granted    = cand;
               res.granted_id  = ID_FIELD_W'(cand);
               found           = 1'b1;
            end
         end
         if (!found) begin
            res.status = ST_FULL;
         end
      end else if (id == 0 || id >= ID_COUNT || !id_in_use[id]) begin
         res.status = ST_BAD_RELEASE;
      end else begin
         id_in_use[id] = 1'b0;
      end
      return res;
   endfunction

   task automatic log_failure(input string what);
      failures++;
      if (failures <= 10) begin
         $display("%0t ns: %s", $time, what);
      end
   endtask

   always @(posedge clock) begin
      nfia_result_type want;
      if (reset) begin
         for (int i = 0; i < ID_COUNT; i++) begin
            id_in_use[i] = 1'b0;
         end
         last_granted = 0;
         awaited_rsps.delete();
         failures     = 0;
         grants       = 0;
         full_answers = 0;
         releases_ok  = 0;
         releases_bad = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsps.size() == 0) begin
               log_failure($sformatf("response transfer with none expected: id %0d status %0d",
                                     rsp_granted_id, rsp_status));
            end else begin
               want = awaited_rsps.pop_front();
               if (rsp_granted_id !== want.granted_id || rsp_status !== want.status) begin
                  log_failure($sformatf(
                     "response mismatch: expected id %0d status %0d, got id %0d status %0d",
                     want.granted_id, want.status, rsp_granted_id, rsp_status));
               end
               if (want.status == ST_FULL) begin
                  full_answers++;
               end else if (want.status == ST_BAD_RELEASE) begin
                  releases_bad++;
               end else if (want.granted_id != '0) begin
                  grants++;
               end else begin
                  releases_ok++;
               end
            end
         end
         if (req_valid && req_ready) begin
            awaited_rsps.push_back(next_fit_outcome(req_op, req_release_id));
         end
      end
      pending = awaited_rsps.size();
   end

endmodule

// ----- dv/next_fit_id_allocator_unit_tb.sv -----
// Testbench top of the next-fit ID allocator: clock, reset, request stimulus with
// random stalls on both channels, and the final verdict from the response checker.
// Depends on nfia_pkg, nfia_if, the allocator RTL and next_fit_id_allocator_unit_checker.
`timescale 1ns / 1ps

module next_fit_id_allocator_unit_tb;
   import nfia_pkg::*;

   localparam int ID_COUNT    = ID_COUNT_DEF;
   localparam int CYCLE_LIMIT = 600000;
   localparam int ID_MAX      = (1 << ID_FIELD_W) - 1;

   typedef enum {ID_GIVEN, ID_HELD_ANY, ID_HELD_NEWEST} id_source_type;

   logic                  clock;
   logic                  reset;
   bit                    calm;
   bit                    full_seen;
   int                    cycles = 0;
   int                    failures;
   int                    pending;
   int                    grants;
   int                    full_answers;
   int                    releases_ok;
   int                    releases_bad;
   logic [ID_FIELD_W-1:0] held_ids [$];

   nfia_req_if req_chan ();
   nfia_rsp_if rsp_chan ();

   next_fit_id_allocator_unit #(
      .ID_COUNT(ID_COUNT)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   next_fit_id_allocator_unit_checker #(
      .ID_COUNT(ID_COUNT)
   ) response_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_chan.ready),
      .req_op        (req_chan.op),
      .req_release_id(req_chan.release_id),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_granted_id(rsp_chan.granted_id),
      .rsp_status    (rsp_chan.status),
      .failures      (failures),
      .pending       (pending),
      .grants        (grants),
      .full_answers  (full_answers),
      .releases_ok   (releases_ok),
      .releases_bad  (releases_bad)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses outstanding.", cycles, pending);
         $display("Verification failed");
         $finish;
      end
   end

   // Granted IDs are remembered so that most releases name an ID really in use.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (rsp_chan.status == ST_OK && rsp_chan.granted_id != '0) begin
            held_ids.push_back(rsp_chan.granted_id);
         end
         if (rsp_chan.status == ST_FULL) begin
            full_seen = 1'b1;
         end
      end
   end

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= calm || ($urandom_range(99) >= 35);
      end
   end

   task automatic send_request(input logic op, input logic [ID_FIELD_W-1:0] id,
                               input id_source_type source);
      int                    pick;
      logic [ID_FIELD_W-1:0] chosen;
      @(negedge clock);
      while (!calm && $urandom_range(99) < 35) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      chosen = id;
      if (source != ID_GIVEN && held_ids.size() > 0) begin
         pick   = (source == ID_HELD_NEWEST) ? held_ids.size() - 1
                                             : $urandom_range(held_ids.size() - 1);
         chosen = held_ids[pick];
         held_ids.delete(pick);
      end
      req_chan.valid      <= 1'b1;
      req_chan.op         <= op;
      req_chan.release_id <= chosen;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending != 0) begin
         @(negedge clock);
      end
   endtask

   function automatic logic [ID_FIELD_W-1:0] any_id();
      return ID_FIELD_W'($urandom_range(ID_MAX));
   endfunction

   initial begin
      int roll;
      int fill_count;
      req_chan.valid      = 1'b0;
      req_chan.op         = OP_ALLOC;
      req_chan.release_id = '0;
      reset               = 1'b1;
      calm                = 1'b0;
      full_seen           = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Releases into an empty map, next-fit order, double release and the zero ID.
      send_request(OP_RELEASE, '0, ID_GIVEN);
      send_request(OP_RELEASE, ID_FIELD_W'(ID_MAX), ID_GIVEN);
      send_request(OP_RELEASE, ID_FIELD_W'(5), ID_GIVEN);
      send_request(OP_ALLOC, ID_FIELD_W'(ID_MAX), ID_GIVEN);
      send_request(OP_ALLOC, '0, ID_GIVEN);
      send_request(OP_RELEASE, ID_FIELD_W'(1), ID_GIVEN);
      send_request(OP_RELEASE, ID_FIELD_W'(1), ID_GIVEN);
      send_request(OP_ALLOC, any_id(), ID_GIVEN);
      send_request(OP_RELEASE, ID_FIELD_W'(3), ID_GIVEN);
      send_request(OP_ALLOC, any_id(), ID_GIVEN);
      send_request(OP_RELEASE, '0, ID_GIVEN);
      send_request(OP_RELEASE, ID_FIELD_W'(2), ID_GIVEN);
      send_request(OP_ALLOC, ID_FIELD_W'(ID_MAX), ID_GIVEN);
      wait_drained();

      repeat (100) begin
         roll = $urandom_range(99);
         if (roll < 55) begin
            send_request(OP_ALLOC, any_id(), ID_GIVEN);
         end else if (roll < 88) begin
            send_request(OP_RELEASE, any_id(), ID_HELD_ANY);
         end else begin
            send_request(OP_RELEASE, any_id(), ID_GIVEN);
         end
      end
      wait_drained();

      // Fill the whole ID space; the first part runs with no stalls on either side.
      full_seen  = 1'b0;
      fill_count = 0;
      calm       = 1'b1;
      while (!full_seen && fill_count < 1200) begin
         send_request(OP_ALLOC, any_id(), ID_GIVEN);
         fill_count++;
         if (fill_count == 300) begin
            calm = 1'b0;
         end
      end
      calm = 1'b0;

      // Churn near full; some rounds free the newest held ID and then allocate again.
      repeat (150) begin
         roll = $urandom_range(99);
         if (roll < 25) begin
            wait_drained();
            send_request(OP_RELEASE, any_id(), ID_HELD_NEWEST);
            send_request(OP_ALLOC, any_id(), ID_GIVEN);
         end else if (roll < 55) begin
            send_request(OP_ALLOC, any_id(), ID_GIVEN);
         end else if (roll < 90) begin
            send_request(OP_RELEASE, any_id(), ID_HELD_ANY);
         end else begin
            send_request(OP_RELEASE, any_id(), ID_GIVEN);
         end
      end

      wait_drained();
      repeat (60) @(posedge clock);
      $display("Run covered %0d grants, %0d allocates with no free ID, %0d accepted releases",
               grants, full_answers, releases_ok);
      $display("and %0d rejected releases, with a full fill and wraparound of the ID space.",
               releases_bad);
      if (failures == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
